>>> design/stkcal_pkg.sv
// Shared constants, types and state codes of the stick calibration and map block.
`default_nettype none

package stkcal_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int AXES         = 4;
   localparam int AXIS_W       = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int CHAN_W       = 3;
   localparam int OUT_W        = 11;
   localparam int FRAC_BITS    = 16;
   localparam int CEN_W        = SAMPLE_BITS + FRAC_BITS;
   localparam int SUM_W        = SAMPLE_BITS + 1;

   // floor(s / 3) as (s * DIV3_MUL) >> DIV3_SHIFT, exact for s below 2**DIV3_SHIFT
   localparam int DIV3_SHIFT   = SUM_W + 1 - (SUM_W % 2);
   localparam int DIV3_MUL     = ((1 << DIV3_SHIFT) + 1) / 3;

   localparam int GAIN_W       = 13;
   localparam logic [GAIN_W-1:0] GAIN_Q16 = 13'd6554;

   // segment numerator: (x - a) * 500 + run / 2
   localparam int NUM_W        = SAMPLE_BITS + 11;
   localparam int MAG_W        = NUM_W - 1;
   localparam int DEN_W        = SAMPLE_BITS;
   localparam int DIV_CNT_W    = $clog2(MAG_W + 1);

   localparam logic [OUT_W-1:0] OUT_LO   = 11'd1000;
   localparam logic [OUT_W-1:0] OUT_MID  = 11'd1500;
   localparam logic [OUT_W-1:0] OUT_HI   = 11'd2000;
   localparam int               SEG_SPAN = 500;
   localparam int               SPAN_MIN = 200;

   localparam int REQ_DATA_W   = ((CHAN_W + SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((CHAN_W + OUT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - CHAN_W - OUT_W;

   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_ENABLE     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_ENABLE = 4'd1;

   localparam logic [SAMPLE_BITS-1:0] LOW_RESET    = '1;
   localparam logic [SAMPLE_BITS-1:0] HIGH_RESET   = '0;
   localparam logic [CEN_W-1:0]       CENTRE_RESET = {1'b1, {(CEN_W-1){1'b0}}};

   typedef struct packed {
      logic [CEN_W-1:0]       centre;
      logic [SAMPLE_BITS-1:0] high;
      logic [SAMPLE_BITS-1:0] low;
   } mark_entry_type;

   localparam mark_entry_type MARK_RESET = '{centre: CENTRE_RESET, high: HIGH_RESET,
                                             low: LOW_RESET};

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [AXIS_W-1:0] addr;
   } mark_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARKS,
      ST_STEP,
      ST_CLAMP,
      ST_SETUP,
      ST_DIV,
      ST_FINAL,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> design/stkcal_mark_ram.sv
// Per-axis mark memory with a registered read (data in the cycle after rd_en) and reset-value valid bits.
`default_nettype none

module stkcal_mark_ram (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire stkcal_pkg::mark_req_type req,
   input  wire stkcal_pkg::mark_entry_type wr_data,
   output stkcal_pkg::mark_entry_type   rd_data
);
   import stkcal_pkg::*;

   mark_entry_type mark_mem_ff [AXES];
   logic [AXES-1:0] valid_ff;
   logic [AXES-1:0] valid_in;
   mark_entry_type  rd_word_ff;
   logic            rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mark_mem_ff[req.addr] <= wr_data;
      end
      if (req.rd_en) begin
         rd_word_ff <= mark_mem_ff[req.addr];
         rd_hit_ff  <= valid_ff[req.addr];
      end
   end

   // an entry never written reads as its reset marks
   assign rd_data = rd_hit_ff ? rd_word_ff : MARK_RESET;

endmodule

`default_nettype wire

>>> design/stkcal_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module stkcal_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [stkcal_pkg::MAG_W-1:0] num,
   input  wire logic [stkcal_pkg::DEN_W-1:0] den,
   output stkcal_pkg::div_status_type       stat,
   output logic [stkcal_pkg::MAG_W-1:0]     quotient
);
   import stkcal_pkg::*;

   logic [DEN_W-1:0]     rem_ff,  rem_in;
   logic [MAG_W-1:0]     quo_ff,  quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      diff    = trial - {1'b0, den};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the shifted remainder when the trial subtract goes negative
         if (diff[DEN_W]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

>>> design/stick_calibrate_and_map_top.sv
// Top level: stick calibration sequencer, three-point pulse map and stream ports.
//
// Input channel req_*: one transaction carries a channel index and a sample.
// Channels below AXES are sticks, the rest buttons (pin low gives 2000 us).
// Result channel rsp_*: one transaction per input with the channel index and
// a pulse width of 1000..2000 us. Config channel csr_*: always ready; index 0
// is cal_enable, index 1 is channel_enable, other indexes are dropped.
// Items are handled one at a time. A button goes from accept straight to the
// done state. A stick reads its marks from the mark memory (ST_MARKS), updates
// them with calibration on (ST_STEP, ST_CLAMP), then sets up the segment
// (ST_SETUP) and divides with the serial divider, one quotient bit per cycle,
// before the final clamp (ST_FINAL). A narrow span or an empty segment skips
// the divider and goes from ST_SETUP to ST_DONE.
// The result sits in an output register; the next input is taken as soon as
// the sequencer is idle, and a finished item waits only while that register
// is still full and rsp_tready is low.
// Reset clears cal_enable, sets every channel_enable bit and marks all stick
// entries of the memory as holding their reset marks; no clearing pass.
`default_nettype none

module stick_calibrate_and_map_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: chan, sample, zero fill
   input  wire logic [stkcal_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // fields from bit 0: out_chan, pulse_us, zero fill
   output logic [stkcal_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [stkcal_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [stkcal_pkg::CSR_DATA_W-1:0] csr_data
);
   import stkcal_pkg::*;

   localparam logic signed [SAMPLE_BITS:0] SPAN_MIN_S = (SAMPLE_BITS+1)'(SPAN_MIN);
   localparam logic signed [NUM_W-1:0]     SEG_SPAN_S = NUM_W'(SEG_SPAN);
   localparam logic signed [MAG_W+1:0]     RES_LO     = (MAG_W+2)'(OUT_LO);
   localparam logic signed [MAG_W+1:0]     RES_HI     = (MAG_W+2)'(OUT_HI);
   localparam int                          PROD_G_W   = CEN_W + GAIN_W;
   localparam int                          PROD_3_W   = SUM_W + DIV3_SHIFT;

   state_type state_ff, state_in;

   logic                   cal_en_ff, cal_en_in;
   logic [7:0]             ch_en_ff,  ch_en_in;
   logic [CHAN_W-1:0]      chan_ff,   chan_in;
   logic [SAMPLE_BITS-1:0] v_ff,      v_in;
   logic                   cal_ff,    cal_in;
   logic [SAMPLE_BITS-1:0] lo_ff,     lo_in;
   logic [SAMPLE_BITS-1:0] hi_ff,     hi_in;
   logic [SUM_W-1:0]       sum_ff,    sum_in;
   logic [CEN_W-1:0]       cen_ff,    cen_in;
   logic                   dneg_ff,   dneg_in;
   logic [CEN_W-1:0]       mag_ff,    mag_in;
   logic [CEN_W-1:0]       stp_ff,    stp_in;
   logic [SAMPLE_BITS-1:0] cmin_ff,   cmin_in;
   logic [MAG_W-1:0]       num_ff,    num_in;
   logic [DEN_W-1:0]       den_ff,    den_in;
   logic                   qneg_ff,   qneg_in;
   logic [OUT_W-1:0]       olo_ff,    olo_in;
   logic [OUT_W-1:0]       pulse_ff,  pulse_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff,  rsp_data_in;

   logic [CHAN_W-1:0]      req_chan;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic                   req_accept;
   logic                   req_stick;
   logic                   req_present;
   logic                   slot_free;

   mark_req_type           mark_req;
   mark_entry_type         mark_wr;
   mark_entry_type         mark_rd;
   logic                   div_start;
   div_status_type         div_stat;
   logic [MAG_W-1:0]       div_quo;

   // learn datapath
   logic [SAMPLE_BITS-1:0] lo_new, hi_new;
   logic signed [CEN_W:0]  dlt;
   logic [CEN_W:0]         dlt_abs;
   logic [PROD_G_W-1:0]    prod_g;
   logic [PROD_3_W-1:0]    prod_3;
   logic [CEN_W-1:0]       cen_step;
   logic [CEN_W-1:0]       cen_floor;
   logic [CEN_W-1:0]       cen_ceil;

   // map setup datapath
   logic [SAMPLE_BITS-1:0]  mid;
   logic                    upper;
   logic [SAMPLE_BITS-1:0]  seg_a, seg_b;
   logic signed [SAMPLE_BITS:0] span, diff, run, run_r, half;
   logic signed [NUM_W-1:0] num_s;
   logic [NUM_W-1:0]        num_abs;
   logic [SAMPLE_BITS:0]    run_abs;
   logic                    narrow;
   logic                    run_zero;

   // final datapath
   logic signed [MAG_W:0]   q_s;
   logic signed [MAG_W+1:0] res_s;

   assign req_chan    = req_tdata[CHAN_W-1:0];
   assign req_sample  = req_tdata[CHAN_W +: SAMPLE_BITS];
   assign req_accept  = req_tvalid && req_tready;
   assign req_stick   = ({1'b0, req_chan} < (CHAN_W+1)'(AXES));
   assign req_present = ch_en_ff[req_chan];
   assign slot_free   = !rsp_valid_ff || rsp_tready;

   stkcal_mark_ram u_marks (
      .clock   (clock),
      .reset   (reset),
      .req     (mark_req),
      .wr_data (mark_wr),
      .rd_data (mark_rd)
   );

   // the divider loads its dividend at the start edge, so hand it the value being built
   stkcal_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_in),
      .den      (den_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // learn: widen marks, step the centre, clamp between sum/3 and sum/2
   always_comb begin
      lo_new    = (cal_ff && (v_ff < mark_rd.low))  ? v_ff : mark_rd.low;
      hi_new    = (cal_ff && (v_ff > mark_rd.high)) ? v_ff : mark_rd.high;
      dlt       = $signed({1'b0, v_ff, {FRAC_BITS{1'b0}}}) - $signed({1'b0, mark_rd.centre});
      dlt_abs   = dlt[CEN_W] ? -dlt : dlt;
      prod_g    = PROD_G_W'(mag_ff) * PROD_G_W'(GAIN_Q16);
      prod_3    = PROD_3_W'(sum_ff) * PROD_3_W'(DIV3_MUL);
      cen_step  = dneg_ff ? (cen_ff - stp_ff) : (cen_ff + stp_ff);
      cen_floor = {cmin_ff, {FRAC_BITS{1'b0}}};
      cen_ceil  = {sum_ff[SUM_W-1:1], {FRAC_BITS{1'b0}}};
   end

   // map setup: pick the segment, build the rounded numerator
   always_comb begin
      mid      = cen_ff[CEN_W-1 -: SAMPLE_BITS];
      span     = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
      narrow   = cal_ff && (span < SPAN_MIN_S);
      upper    = (v_ff >= mid);
      seg_a    = upper ? mid : lo_ff;
      seg_b    = upper ? hi_ff : mid;
      diff     = $signed({1'b0, v_ff}) - $signed({1'b0, seg_a});
      run      = $signed({1'b0, seg_b}) - $signed({1'b0, seg_a});
      // halve toward zero
      run_r    = run + $signed({{SAMPLE_BITS{1'b0}}, run[SAMPLE_BITS]});
      half     = run_r >>> 1;
      num_s    = $signed({{(NUM_W-SAMPLE_BITS-1){diff[SAMPLE_BITS]}}, diff}) * SEG_SPAN_S
                 + $signed({{(NUM_W-SAMPLE_BITS-1){half[SAMPLE_BITS]}}, half});
      num_abs  = num_s[NUM_W-1] ? -num_s : num_s;
      run_abs  = run[SAMPLE_BITS] ? -run : run;
      run_zero = (run == '0);
   end

   always_comb begin
      q_s   = qneg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      res_s = $signed({q_s[MAG_W], q_s}) + $signed({{(MAG_W+2-OUT_W){1'b0}}, olo_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_stick ? ST_MARKS : ST_DONE;
            end
         end
         ST_MARKS: state_in = cal_ff ? ST_STEP : ST_SETUP;
         ST_STEP:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_SETUP;
         ST_SETUP: state_in = (narrow || run_zero) ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs to ports, mark memory and divider
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      mark_req.rd_en = (state_ff == ST_IDLE) && req_accept && req_stick;
      mark_req.wr_en = (state_ff == ST_SETUP) && cal_ff;
      mark_req.addr  = (state_ff == ST_IDLE) ? req_chan[AXIS_W-1:0] : chan_ff[AXIS_W-1:0];
      mark_wr.centre = cen_ff;
      mark_wr.high   = hi_ff;
      mark_wr.low    = lo_ff;
      div_start      = (state_ff == ST_SETUP) && !narrow && !run_zero;
   end

   // datapath registers
   always_comb begin
      chan_in  = chan_ff;
      v_in     = v_ff;
      cal_in   = cal_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      sum_in   = sum_ff;
      cen_in   = cen_ff;
      dneg_in  = dneg_ff;
      mag_in   = mag_ff;
      stp_in   = stp_ff;
      cmin_in  = cmin_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      qneg_in  = qneg_ff;
      olo_in   = olo_ff;
      pulse_in = pulse_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               chan_in  = req_chan;
               v_in     = req_present ? req_sample : '0;
               cal_in   = cal_en_ff;
               pulse_in = (req_present && !req_sample[0]) ? OUT_HI : OUT_LO;
            end
         end
         ST_MARKS: begin
            lo_in   = lo_new;
            hi_in   = hi_new;
            sum_in  = {1'b0, lo_new} + {1'b0, hi_new};
            cen_in  = mark_rd.centre;
            dneg_in = dlt[CEN_W];
            mag_in  = dlt_abs[CEN_W-1:0];
         end
         ST_STEP: begin
            stp_in  = prod_g[FRAC_BITS +: CEN_W];
            cmin_in = prod_3[DIV3_SHIFT +: SAMPLE_BITS];
         end
         ST_CLAMP: begin
            if (cen_step < cen_floor) begin
               cen_in = cen_floor;
            end else if (cen_step > cen_ceil) begin
               cen_in = cen_ceil;
            end else begin
               cen_in = cen_step;
            end
         end
         ST_SETUP: begin
            num_in  = num_abs[MAG_W-1:0];
            den_in  = run_abs[DEN_W-1:0];
            qneg_in = num_s[NUM_W-1] ^ run[SAMPLE_BITS];
            olo_in  = upper ? OUT_MID : OUT_LO;
            if (narrow) begin
               pulse_in = OUT_MID;
            end else if (run_zero) begin
               pulse_in = upper ? OUT_MID : OUT_LO;
            end
         end
         ST_FINAL: begin
            if (res_s < RES_LO) begin
               pulse_in = OUT_LO;
            end else if (res_s > RES_HI) begin
               pulse_in = OUT_HI;
            end else begin
               pulse_in = res_s[OUT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // config and result register
   always_comb begin
      cal_en_in = cal_en_ff;
      ch_en_in  = ch_en_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAL_ENABLE:     cal_en_in = csr_data[0];
            CSR_CHANNEL_ENABLE: ch_en_in  = csr_data;
            default: begin
            end
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_DONE) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, pulse_ff, chan_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_en_ff    <= 1'b0;
         ch_en_ff     <= 8'hFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_en_ff    <= cal_en_in;
         ch_en_ff     <= ch_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      v_ff        <= v_in;
      cal_ff      <= cal_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sum_ff      <= sum_in;
      cen_ff      <= cen_in;
      dneg_ff     <= dneg_in;
      mag_ff      <= mag_in;
      stp_ff      <= stp_in;
      cmin_ff     <= cmin_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      qneg_ff     <= qneg_in;
      olo_ff      <= olo_in;
      pulse_ff    <= pulse_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in flight");

   a_read_then_marks: assert property (@(posedge clock) disable iff (reset)
      mark_req.rd_en |=> (state_ff == ST_MARKS))
      else $error("mark read not followed by mark stage");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide stage");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[CHAN_W +: OUT_W] >= OUT_LO) &&
                      (rsp_tdata[CHAN_W +: OUT_W] <= OUT_HI)))
      else $error("pulse width out of range");

endmodule

`default_nettype wire
